// ----- design/tcr_pkg.sv -----
// text console renderer: shared types and constants
// no dependencies; used by every module of the block
package tcr_pkg;

    // operation codes of an input beat
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_FONT  = 2'd1;
    localparam logic [1:0] OP_PIXEL = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // configuration register indexes
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    localparam logic [15:0] FG_RESET = 16'hFFFF;
    localparam logic [15:0] BG_RESET = 16'h0000;

    localparam logic [7:0] CODE_LF    = 8'h0A;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] CODE_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MASK  = 8'h7F;

    localparam int FONT_BYTES = 480;
    localparam int FONT_AW    = 9;
    localparam int CELL_W     = 6;
    localparam int CELL_H_LOG = 3;
    localparam int GLYPH_W    = 5;

    // px / 6 as (px * 171) >> 10, exact for any 8-bit px
    localparam int DIV6_MUL   = 171;
    localparam int DIV6_SHIFT = 10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_code;
        logic       end_of_text;
        logic [8:0] font_index;
        logic [7:0] font_byte;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixel_color;
        logic        refresh_request;
    } t_out_item;

    // classified command held in the queue
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] code;
        logic       eot;
        logic [8:0] font_index;
        logic [7:0] font_byte;
        logic [5:0] cell_x;
        logic [4:0] cell_y;
        logic       in_grid;
        logic [2:0] glyph_col;
        logic [2:0] glyph_row;
    } t_cmd;

endpackage

// ----- design/tcr_front.sv -----
// text console renderer: front end, accepts beats and classifies them
// uses tcr_pkg; feeds tcr_queue
module tcr_front #(
    parameter int TEXT_COLS = 40,
    parameter int TEXT_ROWS = 30
) (
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tcr_pkg::t_in_item i_item,
    input  logic             i_queue_full,
    input  logic             i_busy,
    output logic             o_push,
    output tcr_pkg::t_cmd    o_cmd
);

    logic [17:0] div_prod;
    logic [5:0]  cell_x;
    logic [4:0]  cell_y;
    logic [7:0]  col_base;

    always_comb begin
        div_prod = 18'(int'(i_item.pixel_x) * tcr_pkg::DIV6_MUL);
        cell_x   = 6'(div_prod >> tcr_pkg::DIV6_SHIFT);
        col_base = 8'(int'(cell_x) * tcr_pkg::CELL_W);
        cell_y   = i_item.pixel_y[7:tcr_pkg::CELL_H_LOG];
    end

    always_comb begin
        o_cmd.op         = i_item.operation;
        o_cmd.code       = i_item.char_code;
        o_cmd.eot        = i_item.end_of_text;
        o_cmd.font_index = i_item.font_index;
        o_cmd.font_byte  = i_item.font_byte;
        o_cmd.cell_x     = cell_x;
        o_cmd.cell_y     = cell_y;
        o_cmd.in_grid    = (int'(cell_x) < TEXT_COLS) && (int'(cell_y) < TEXT_ROWS);
        o_cmd.glyph_col  = 3'(i_item.pixel_x - col_base);
        o_cmd.glyph_row  = i_item.pixel_y[tcr_pkg::CELL_H_LOG-1:0];
    end

    assign o_in_stall = i_queue_full || i_busy;
    // unused operation code is taken and dropped here
    assign o_push = i_in_valid && !o_in_stall && (i_item.operation != tcr_pkg::OP_NONE);

endmodule

// ----- design/tcr_queue.sv -----
// text console renderer: short command queue between front and back
// uses tcr_pkg
module tcr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcr_pkg::t_cmd i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output tcr_pkg::t_cmd o_head
);

    tcr_pkg::t_cmd r_slot [tcr_pkg::QUEUE_DEPTH];
    logic [tcr_pkg::QUEUE_AW-1:0] r_wr;
    logic [tcr_pkg::QUEUE_AW-1:0] r_rd;
    logic [tcr_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = (int'(r_count) == tcr_pkg::QUEUE_DEPTH);
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

// ----- design/tcr_back.sv -----
// text console renderer: back end, grid and font memories, cursor, scroll
// and pixel lookup; uses tcr_pkg, pops commands from tcr_queue
module tcr_back #(
    parameter int TEXT_COLS = 40,
    parameter int TEXT_ROWS = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_q_empty,
    input  tcr_pkg::t_cmd      i_head,
    output logic               o_pop,
    output logic               o_busy,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcr_pkg::t_out_item o_item
);

    localparam int CELLS   = TEXT_COLS * TEXT_ROWS;
    localparam int GRID_AW = $clog2(CELLS);
    localparam int COL_W   = $clog2(TEXT_COLS + 1);
    localparam int ROW_W   = $clog2(TEXT_ROWS + 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_PIX_G  = 3'd2;
    localparam logic [2:0] ST_PIX_F  = 3'd3;
    localparam logic [2:0] ST_SCROLL = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;

    logic [7:0] grid_mem [CELLS];
    logic [7:0] font_mem [tcr_pkg::FONT_BYTES];

    logic [2:0]         r_state, n_state;
    logic [GRID_AW-1:0] r_ptr, n_ptr;
    logic               r_wr_pend, n_wr_pend;
    logic [GRID_AW-1:0] r_wr_addr, n_wr_addr;
    logic               r_init, n_init;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [15:0]        r_fg;
    logic [15:0]        r_bg;
    logic               r_out_valid;
    tcr_pkg::t_out_item r_out;

    logic [7:0] r_gdat;
    logic [7:0] r_fdat;
    logic [2:0] r_k;
    logic [2:0] r_j;
    logic       r_in_grid;

    logic                        out_free;
    logic                        out_load;
    tcr_pkg::t_out_item          out_data;
    logic                        g_we;
    logic [GRID_AW-1:0]          g_waddr;
    logic [7:0]                  g_wdata;
    logic                        g_re;
    logic [GRID_AW-1:0]          g_raddr;
    logic                        f_we;
    logic                        f_re;
    logic [tcr_pkg::FONT_AW-1:0] f_raddr;
    logic [COL_W-1:0]            col_inc;
    logic [ROW_W-1:0]            row_inc;
    logic [ROW_W-1:0]            put_row;
    logic [COL_W-1:0]            put_col;
    logic [7:0]                  glyph_char;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_item      = r_out;
    assign o_busy      = r_init;

    always_comb begin
        o_pop      = 1'b0;
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_wr_pend  = r_wr_pend;
        n_wr_addr  = r_wr_addr;
        n_init     = r_init;
        n_row      = r_row;
        n_col      = r_col;
        g_we       = 1'b0;
        g_waddr    = r_ptr;
        g_wdata    = '0;
        g_re       = 1'b0;
        g_raddr    = r_ptr;
        f_we       = 1'b0;
        f_re       = 1'b0;
        out_load   = 1'b0;
        out_data   = '0;
        col_inc    = r_col + 1'b1;
        row_inc    = r_row + 1'b1;
        put_row    = r_row;
        put_col    = r_col;

        glyph_char = r_in_grid ? (r_gdat & tcr_pkg::CHAR_MASK) : tcr_pkg::CODE_SPACE;
        if (glyph_char < tcr_pkg::CODE_SPACE) begin
            glyph_char = tcr_pkg::CODE_SPACE;
        end
        f_raddr = tcr_pkg::FONT_AW'(int'(glyph_char - tcr_pkg::CODE_SPACE) * tcr_pkg::GLYPH_W
                                    + int'(r_k));

        unique case (r_state)
            ST_CLEAR: begin
                g_we = 1'b1;
                if (int'(r_ptr) == CELLS - 1) begin
                    n_state = ST_IDLE;
                    n_init  = 1'b0;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_IDLE: begin
                // a refresh notice needs the output register at pop time
                if (!i_q_empty && !(i_head.op == tcr_pkg::OP_PUT && i_head.eot && !out_free))
                begin
                    o_pop = 1'b1;
                    unique case (i_head.op)
                        tcr_pkg::OP_PUT: begin
                            if (i_head.code == tcr_pkg::CODE_CR) begin
                                put_row = r_row;
                                put_col = r_col;
                            end else if (i_head.code == tcr_pkg::CODE_LF) begin
                                put_row = row_inc;
                                put_col = '0;
                            end else begin
                                g_we    = 1'b1;
                                g_waddr = GRID_AW'(int'(r_row) * TEXT_COLS + int'(r_col));
                                g_wdata = i_head.code;
                                if (int'(col_inc) == TEXT_COLS) begin
                                    put_row = row_inc;
                                    put_col = '0;
                                end else begin
                                    put_col = col_inc;
                                end
                            end
                            n_col = put_col;
                            n_row = put_row;
                            if (int'(put_row) == TEXT_ROWS) begin
                                n_row     = ROW_W'(TEXT_ROWS - 1);
                                n_state   = ST_SCROLL;
                                n_ptr     = GRID_AW'(TEXT_COLS);
                                n_wr_pend = 1'b0;
                            end
                            if (i_head.eot) begin
                                out_load                 = 1'b1;
                                out_data.pixel_color     = '0;
                                out_data.refresh_request = 1'b1;
                            end
                        end
                        tcr_pkg::OP_FONT: begin
                            f_we = (int'(i_head.font_index) < tcr_pkg::FONT_BYTES);
                        end
                        tcr_pkg::OP_PIXEL: begin
                            g_re    = 1'b1;
                            g_raddr = GRID_AW'(int'(i_head.cell_y) * TEXT_COLS
                                               + int'(i_head.cell_x));
                            n_state = ST_PIX_G;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PIX_G: begin
                f_re    = (int'(r_k) < tcr_pkg::GLYPH_W);
                n_state = ST_PIX_F;
            end
            ST_PIX_F: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data.pixel_color = ((int'(r_k) < tcr_pkg::GLYPH_W) && r_fdat[r_j])
                                           ? r_fg : r_bg;
                    out_data.refresh_request = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            ST_SCROLL: begin
                // read one row down, write the previous read one row up
                g_re      = 1'b1;
                g_raddr   = r_ptr;
                g_we      = r_wr_pend;
                g_waddr   = r_wr_addr;
                g_wdata   = r_gdat;
                n_wr_addr = GRID_AW'(int'(r_ptr) - TEXT_COLS);
                n_wr_pend = 1'b1;
                if (int'(r_ptr) == CELLS - 1) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_DRAIN: begin
                g_we      = 1'b1;
                g_waddr   = r_wr_addr;
                g_wdata   = r_gdat;
                n_wr_pend = 1'b0;
                n_ptr     = GRID_AW'((TEXT_ROWS - 1) * TEXT_COLS);
                n_state   = ST_CLEAR;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ptr       <= '0;
            r_wr_pend   <= 1'b0;
            r_wr_addr   <= '0;
            r_init      <= 1'b1;
            r_row       <= '0;
            r_col       <= '0;
            r_fg        <= tcr_pkg::FG_RESET;
            r_bg        <= tcr_pkg::BG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_wr_pend <= n_wr_pend;
            r_wr_addr <= n_wr_addr;
            r_init    <= n_init;
            r_row     <= n_row;
            r_col     <= n_col;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tcr_pkg::REG_FG: r_fg <= i_cfg_data;
                    tcr_pkg::REG_BG: r_bg <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_data;
        end
        if (o_pop && i_head.op == tcr_pkg::OP_PIXEL) begin
            r_k       <= i_head.glyph_col;
            r_j       <= i_head.glyph_row;
            r_in_grid <= i_head.in_grid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            grid_mem[g_waddr] <= g_wdata;
        end
        if (g_re) begin
            r_gdat <= grid_mem[g_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            font_mem[i_head.font_index] <= i_head.font_byte;
        end
        if (f_re) begin
            r_fdat <= font_mem[f_raddr];
        end
    end

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_col) < TEXT_COLS)
        else $error("cursor column beyond grid");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_row) < TEXT_ROWS)
        else $error("cursor row beyond grid");

    a_init_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> (r_state == ST_CLEAR && !o_pop))
        else $error("command taken during reset clearing pass");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL) |-> (int'(r_row) == TEXT_ROWS - 1))
        else $error("scroll with cursor off the bottom row");

    a_notice_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_out))
        else $error("result overwritten while held");
`endif

endmodule

// ----- design/text_console_renderer.sv -----
// text console renderer: top level
// uses tcr_pkg, tcr_front, tcr_queue, tcr_back
//
// input channel: i_in_valid / o_in_stall carry one command beat (i_item):
// put character, load font byte or read pixel. output channel:
// o_out_valid / i_out_stall carry a pixel colour or a refresh notice.
// colours are set through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must set them only while idle, as the block does not enforce this.
// beats go through a four-entry command queue, so input keeps flowing
// while a result waits in the output register.
// in the back end a put character or a font load is handled in the idle
// state; a read pixel passes the grid read, the font read and the result
// state, the two registered memory reads lying in series. a row overflow
// adds a copy of each row one row up and a clear of the bottom row.
// in an idle block with an empty queue a beat reaches the back end the
// cycle after it is taken; a refresh notice is loaded into the output
// register when its beat is popped. after reset every grid cell is cleared
// with o_in_stall high; config writes are still taken.
// a stall on the output holds the result; the queue then fills and
// o_in_stall rises.
module text_console_renderer #(
    parameter int TEXT_COLS = 40,
    parameter int TEXT_ROWS = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcr_pkg::t_in_item  i_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcr_pkg::t_out_item o_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    logic          push;
    tcr_pkg::t_cmd push_cmd;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    tcr_pkg::t_cmd head;
    logic          busy;

    tcr_front #(
        .TEXT_COLS(TEXT_COLS),
        .TEXT_ROWS(TEXT_ROWS)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_item       (i_item),
        .i_queue_full (q_full),
        .i_busy       (busy),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    tcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    tcr_back #(
        .TEXT_COLS(TEXT_COLS),
        .TEXT_ROWS(TEXT_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_item      (o_item)
    );

endmodule

// ----- tb/sv/text_console_renderer_test.sv -----
`timescale 1ns / 1ps
// text console renderer testbench: scoreboard with its own model of grid, cursor and font,
// directed and random beats, random idling on both channels
// depends on tcr_pkg and text_console_renderer

class render_scoreboard #(parameter int COLS = 40, parameter int ROWS = 30);
    logic [7:0]         grid [COLS*ROWS];
    logic [7:0]         glyphs [tcr_pkg::FONT_BYTES];
    int                 cur_row;
    int                 cur_col;
    logic [15:0]        fg;
    logic [15:0]        bg;
    tcr_pkg::t_out_item due_results [$];
    int                 fails;
    int                 mismatches;
    int                 results_seen;
    int                 scrolls;
    int                 pixel_reads;
    int                 notices;
    int                 beats_in;

    function new();
        foreach (grid[i]) grid[i] = 8'h00;
        foreach (glyphs[i]) glyphs[i] = 8'h00;
        cur_row      = 0;
        cur_col      = 0;
        fg           = tcr_pkg::FG_RESET;
        bg           = tcr_pkg::BG_RESET;
        fails        = 0;
        mismatches   = 0;
        results_seen = 0;
        scrolls      = 0;
        pixel_reads  = 0;
        notices      = 0;
        beats_in     = 0;
    endfunction

    function void set_colour(input logic idx, input logic [15:0] val);
        if (idx == tcr_pkg::REG_FG) fg = val;
        else bg = val;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    function void place_char(input logic [7:0] code);
        if (code == tcr_pkg::CODE_CR) begin
        end else if (code == tcr_pkg::CODE_LF) begin
            cur_row++;
            cur_col = 0;
        end else begin
            grid[cur_row*COLS + cur_col] = code;
            cur_col++;
        end
        if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
        end
        // cursor ran off the bottom: shift rows up, blank the last one
        if (cur_row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++) grid[i] = grid[i + COLS];
            for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++) grid[i] = 8'h00;
            cur_row = ROWS - 1;
            scrolls++;
        end
    endfunction

    function logic [15:0] render_pixel(input logic [7:0] px, input logic [7:0] py);
        int         cx;
        int         k;
        int         cy;
        int         j;
        int         addr;
        logic [7:0] code;
        cx = int'(px) / tcr_pkg::CELL_W;
        k  = int'(px) % tcr_pkg::CELL_W;
        cy = int'(py) >> tcr_pkg::CELL_H_LOG;
        j  = int'(py) % (1 << tcr_pkg::CELL_H_LOG);
        code = tcr_pkg::CODE_SPACE;
        if (cx < COLS && cy < ROWS) code = grid[cy*COLS + cx] & tcr_pkg::CHAR_MASK;
        if (code < tcr_pkg::CODE_SPACE) code = tcr_pkg::CODE_SPACE;
        if (k < tcr_pkg::GLYPH_W) begin
            addr = tcr_pkg::GLYPH_W * (int'(code) - int'(tcr_pkg::CODE_SPACE)) + k;
            if (addr < tcr_pkg::FONT_BYTES && glyphs[addr][j]) return fg;
        end
        return bg;
    endfunction

    function void note_beat(input tcr_pkg::t_in_item it);
        tcr_pkg::t_out_item r;
        beats_in++;
        case (it.operation)
            tcr_pkg::OP_PUT: begin
                place_char(it.char_code);
                if (it.end_of_text) begin
                    r.pixel_color     = 16'h0000;
                    r.refresh_request = 1'b1;
                    due_results.push_back(r);
                    notices++;
                end
            end
            tcr_pkg::OP_FONT: begin
                if (it.font_index < tcr_pkg::FONT_BYTES)
                    glyphs[it.font_index] = it.font_byte;
            end
            tcr_pkg::OP_PIXEL: begin
                r.pixel_color     = render_pixel(it.pixel_x, it.pixel_y);
                r.refresh_request = 1'b0;
                due_results.push_back(r);
                pixel_reads++;
            end
            default: begin
            end
        endcase
    endfunction

    function void check_beat(input tcr_pkg::t_out_item got);
        tcr_pkg::t_out_item want;
        results_seen++;
        if (due_results.size() == 0) begin
            fails++;
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d with nothing due: colour %h refresh %b",
                         results_seen, got.pixel_color, got.refresh_request);
            return;
        end
        want = due_results.pop_front();
        if (got.pixel_color !== want.pixel_color ||
                got.refresh_request !== want.refresh_request) begin
            fails++;
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: colour %h refresh %b, expected colour %h refresh %b",
                         results_seen, got.pixel_color, got.refresh_request,
                         want.pixel_color, want.refresh_request);
        end
    endfunction
endclass

module text_console_renderer_test;
    localparam int  TEXT_COLS     = 40;
    localparam int  TEXT_ROWS     = 30;
    localparam int  CELL_H        = 1 << tcr_pkg::CELL_H_LOG;
    localparam int  GRID_W        = TEXT_COLS * tcr_pkg::CELL_W;
    localparam int  GRID_H        = TEXT_ROWS * CELL_H;
    localparam int  SCROLL_CYCLES = 2 + TEXT_ROWS * TEXT_COLS;
    localparam int  DRAIN_CYCLES  = (tcr_pkg::QUEUE_DEPTH + 2) * SCROLL_CYCLES;
    localparam int  RANDOM_BEATS  = 1140;
    localparam int  PHASES        = 6;
    localparam longint RUN_LIMIT_NS = 64'd50_000_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    tcr_pkg::t_in_item  i_item;
    logic               o_out_valid;
    logic               i_out_stall;
    tcr_pkg::t_out_item o_item;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [15:0]        i_cfg_data;

    render_scoreboard #(TEXT_COLS, TEXT_ROWS) sb;
    bit tx_quiet;

    text_console_renderer #(
        .TEXT_COLS(TEXT_COLS),
        .TEXT_ROWS(TEXT_ROWS)
    ) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    function automatic tcr_pkg::t_in_item random_fill();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(tcr_pkg::t_in_item)-1:0];
    endfunction

    function automatic tcr_pkg::t_in_item put_item(input logic [7:0] code, input logic eot);
        tcr_pkg::t_in_item it;
        it = random_fill();
        it.operation   = tcr_pkg::OP_PUT;
        it.char_code   = code;
        it.end_of_text = eot;
        return it;
    endfunction

    function automatic tcr_pkg::t_in_item font_item(input logic [8:0] idx,
                                                    input logic [7:0] val);
        tcr_pkg::t_in_item it;
        it = random_fill();
        it.operation  = tcr_pkg::OP_FONT;
        it.font_index = idx;
        it.font_byte  = val;
        return it;
    endfunction

    function automatic tcr_pkg::t_in_item pixel_item(input logic [7:0] x, input logic [7:0] y);
        tcr_pkg::t_in_item it;
        it = random_fill();
        it.operation = tcr_pkg::OP_PIXEL;
        it.pixel_x   = x;
        it.pixel_y   = y;
        return it;
    endfunction

    // valid stays high from one beat to the next when there is no gap
    task automatic send_beat(input tcr_pkg::t_in_item it);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_item     <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(it);
    endtask

    // one print: printable text with the odd cr or lf, last byte flagged
    task automatic send_print();
        int         len;
        logic [7:0] code;
        len = $urandom_range(1, 12);
        for (int n = 0; n < len; n++) begin
            case ($urandom_range(0, 19))
                0, 1:    code = tcr_pkg::CODE_LF;
                2:       code = tcr_pkg::CODE_CR;
                default: code = 8'($urandom_range(32, 126));
            endcase
            send_beat(put_item(code, n == len - 1));
        end
    endtask

    // all results in, then long enough for a scroll still in the queue to finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_colours(input logic [15:0] fg, input logic [15:0] bg);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tcr_pkg::REG_FG;
        i_cfg_data  <= fg;
        @(posedge i_clk);
        sb.set_colour(tcr_pkg::REG_FG, fg);
        i_cfg_index <= tcr_pkg::REG_BG;
        i_cfg_data  <= bg;
        @(posedge i_clk);
        sb.set_colour(tcr_pkg::REG_BG, bg);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int gap;
        int got_count;
        bit rx_quiet;
        got_count = 0;
        rx_quiet  = 1'b0;
        i_out_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (got_count % 48 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            gap = rx_quiet ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_beat(o_item);
            got_count++;
        end
    end

    initial begin
        int                target;
        int                pick;
        int                step;
        bit                paused;
        tcr_pkg::t_in_item it;
        sb       = new();
        tx_quiet = 1'b0;
        paused   = 1'b0;
        step     = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_item      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= tcr_pkg::REG_FG;
        i_cfg_data  <= 16'h0000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // whole font first, so no pixel read ever meets an unwritten byte
        for (int a = 0; a < tcr_pkg::FONT_BYTES; a++)
            send_beat(font_item(9'(a), 8'($urandom)));

        send_beat(pixel_item(8'd0, 8'd0));              // cleared grid reads as space
        send_beat(font_item(9'd0, 8'h00));
        send_beat(font_item(9'd479, 8'hFF));            // last column of the last glyph
        send_beat(font_item(9'd480, 8'hAA));            // past the store, dropped
        send_beat(font_item(9'd511, 8'h55));
        send_beat(font_item(9'd167, 8'hFF));            // middle column of 'A' solid
        send_beat(put_item(8'h41, 1'b0));
        send_beat(put_item(8'hFF, 1'b0));               // top bit masked off
        send_beat(put_item(8'h80, 1'b0));               // masks to a control code
        send_beat(put_item(tcr_pkg::CODE_CR, 1'b1));    // ignored but still flags refresh
        send_beat(put_item(8'h7E, 1'b1));
        send_beat(put_item(tcr_pkg::CODE_LF, 1'b1));
        send_beat(put_item(8'h00, 1'b0));
        send_beat(put_item(8'h1F, 1'b0));
        send_beat(pixel_item(8'd2, 8'd0));
        send_beat(pixel_item(8'd2, 8'd7));
        send_beat(pixel_item(8'd5, 8'd3));              // padding column
        send_beat(pixel_item(8'd10, 8'd7));
        send_beat(pixel_item(8'd12, 8'd0));
        send_beat(pixel_item(8'd0, 8'd8));
        send_beat(pixel_item(8'd239, 8'd239));          // bottom right cell, padding
        send_beat(pixel_item(8'd234, 8'd232));
        send_beat(pixel_item(8'd240, 8'd0));            // right of the grid
        send_beat(pixel_item(8'd0, 8'd240));            // below the grid
        send_beat(pixel_item(8'd255, 8'd255));
        it = random_fill();
        it.operation = tcr_pkg::OP_NONE;
        send_beat(it);

        for (int ph = 0; ph < PHASES; ph++) begin
            // phase 0 runs on the reset colours
            if (ph > 0) begin
                settle();
                case (ph)
                    1:       write_colours(16'h0000, 16'hFFFF);
                    3:       write_colours(16'hFFFF, 16'h0000);
                    default: write_colours(16'($urandom), 16'($urandom));
                endcase
            end
            target = sb.beats_in + RANDOM_BEATS / PHASES;
            while (sb.beats_in < target) begin
                if (step % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
                step++;
                if (ph == 2 && !paused && sb.beats_in >= target - RANDOM_BEATS / PHASES / 2) begin
                    paused = 1'b1;
                    i_in_valid <= 1'b0;
                    while (sb.pending() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    if ($urandom_range(0, 4) == 0)
                        send_beat(pixel_item(8'($urandom), 8'($urandom)));
                    else
                        send_beat(pixel_item(8'($urandom_range(0, GRID_W - 1)),
                                             8'($urandom_range(0, GRID_H - 1))));
                end else if (pick < 70) begin
                    send_print();
                end else if (pick < 85) begin
                    send_beat(put_item(8'($urandom), 1'($urandom)));
                end else if (pick < 95) begin
                    send_beat(font_item(9'($urandom), 8'($urandom)));
                end else begin
                    it = random_fill();
                    it.operation = tcr_pkg::OP_NONE;
                    send_beat(it);
                end
            end
        end

        settle();
        $display("covered %0d beats: %0d pixel reads, %0d refresh notices, %0d scrolls",
                 sb.beats_in, sb.pixel_reads, sb.notices, sb.scrolls);
        $display("colours: reset pair, both extreme pairs and three random pairs");
        if (sb.fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
